@@ hdl/gxb_pkg.sv @@
`default_nettype none

package gxb_pkg;

  // Request codes carried on req_type_i
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } gxb_req_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;    // capture a new transaction
    logic     reduce;  // fold the addressed slot into the accumulator
    logic     elim;    // clear the new pivot out of the addressed slot
    logic     finish;  // commit and register the result
    gxb_req_e op;
  } gxb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic acc_zero;  // reduced word is all zero
    logic acc_bit;   // reduced word bit at the addressed slot
  } gxb_status_t;

endpackage

`default_nettype wire

@@ hdl/gxb_ctrl.sv @@
`default_nettype none

module gxb_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [4:0]                   pivot_index_i,
  input  wire gxb_pkg::gxb_status_t         status_i,
  output gxb_pkg::gxb_cmd_t                 cmd_o,
  output logic [$clog2(WORD_BITS)-1:0]      slot_idx_o,
  output logic [$clog2(WORD_BITS)-1:0]      pivot_o,
  output logic                              done_o
);

  localparam int unsigned IW = $clog2(WORD_BITS);
  localparam logic [IW-1:0] LAST = IW'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_PIVOT,
    S_ELIM,
    S_FINISH
  } state_e;

  state_e            state_q;
  gxb_pkg::gxb_req_e req_q;
  logic [IW-1:0]     cnt_q;
  logic [IW-1:0]     pivot_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= gxb_pkg::REQ_INSERT;
      cnt_q   <= '0;
      pivot_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q <= gxb_pkg::gxb_req_e'(req_type_i);
            unique case (gxb_pkg::gxb_req_e'(req_type_i))
              gxb_pkg::REQ_INSERT, gxb_pkg::REQ_QUERY: begin
                cnt_q   <= '0;
                state_q <= S_REDUCE;
              end
              gxb_pkg::REQ_READ: begin
                // address the requested slot for the read in FINISH
                cnt_q   <= IW'(pivot_index_i);
                state_q <= S_FINISH;
              end
              default: begin
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_REDUCE: begin
          if (cnt_q == LAST) begin
            state_q <= (req_q == gxb_pkg::REQ_QUERY) ? S_FINISH : S_CHECK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CHECK: begin
          if (status_i.acc_zero) begin
            state_q <= S_FINISH;
          end else begin
            cnt_q   <= LAST;
            state_q <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          // scan down for the top set bit of the reduced word
          if (status_i.acc_bit) begin
            pivot_q <= cnt_q;
            cnt_q   <= '0;
            state_q <= S_ELIM;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_ELIM: begin
          if (cnt_q == LAST) begin
            state_q <= S_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FINISH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start;
    cmd_o.reduce = (state_q == S_REDUCE);
    cmd_o.elim   = (state_q == S_ELIM);
    cmd_o.finish = (state_q == S_FINISH);
    cmd_o.op     = req_q;
  end

  assign busy       = (state_q != S_IDLE);
  assign slot_idx_o = cnt_q;
  assign pivot_o    = pivot_q;
  assign done_o     = done_q;

  a_pivot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIVOT) |-> !status_i.acc_zero)
    else $error("pivot scan on a zero word");

  a_elim_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ELIM) |-> (req_q == gxb_pkg::REQ_INSERT))
    else $error("elimination outside an insert");

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_FINISH) && (state_q == S_IDLE))
    else $error("result strobe without a finish step");

endmodule

`default_nettype wire

@@ hdl/gxb_datapath.sv @@
`default_nettype none

module gxb_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gxb_pkg::gxb_cmd_t            cmd_i,
  input  wire logic [$clog2(WORD_BITS)-1:0] slot_idx_i,
  input  wire logic [$clog2(WORD_BITS)-1:0] pivot_i,
  input  wire logic [31:0]                  vector_value_i,
  input  wire logic [4:0]                   pivot_index_i,
  output gxb_pkg::gxb_status_t              status_o,
  output logic                              added_o,
  output logic                              in_span_o,
  output logic [5:0]                        rank_o,
  output logic                              slot_valid_o,
  output logic [31:0]                       slot_value_o
);

  localparam int unsigned RW = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  word_t          basis_q [WORD_BITS];
  word_t          valid_q;
  logic [RW-1:0]  rank_q;
  word_t          w_q;
  word_t          acc_q;
  logic [4:0]     pidx_q;

  logic           added_q;
  logic           in_span_q;
  logic [5:0]     rank_out_q;
  logic           slot_valid_q;
  logic [31:0]    slot_value_q;

  word_t          rd_word;
  logic           acc_zero;
  logic           add_en;
  logic           clr_en;
  logic           elim_hit;
  logic           rd_hit;
  logic [RW-1:0]  rank_d;

  assign rd_word  = basis_q[slot_idx_i];
  assign acc_zero = (acc_q == '0);
  assign add_en   = cmd_i.finish && (cmd_i.op == gxb_pkg::REQ_INSERT) && !acc_zero;
  assign clr_en   = cmd_i.finish && (cmd_i.op == gxb_pkg::REQ_CLEAR);
  assign elim_hit = (slot_idx_i != pivot_i) && valid_q[slot_idx_i] && rd_word[pivot_i];
  assign rd_hit   = (32'(pidx_q) < 32'(WORD_BITS)) && valid_q[slot_idx_i];

  always_comb begin
    rank_d = rank_q;
    if (clr_en) begin
      rank_d = '0;
    end else if (add_en) begin
      rank_d = rank_q + 1'b1;
    end
  end

  assign status_o.acc_zero = acc_zero;
  assign status_o.acc_bit  = acc_q[slot_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
    end else begin
      rank_q <= rank_d;
      if (clr_en) begin
        valid_q <= '0;
      end else if (add_en) begin
        valid_q[pivot_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q    <= word_t'(vector_value_i);
      acc_q  <= word_t'(vector_value_i);
      pidx_q <= pivot_index_i;
    end
    if (cmd_i.reduce && valid_q[slot_idx_i] && w_q[slot_idx_i]) begin
      acc_q <= acc_q ^ rd_word;
    end
    // drop the new pivot bit from every other stored vector
    if (cmd_i.elim && elim_hit) begin
      basis_q[slot_idx_i] <= rd_word ^ acc_q;
    end
    if (add_en) begin
      basis_q[pivot_i] <= acc_q;
    end
    if (cmd_i.finish) begin
      added_q      <= add_en;
      in_span_q    <= (cmd_i.op == gxb_pkg::REQ_QUERY) && acc_zero;
      rank_out_q   <= 6'(rank_d);
      slot_valid_q <= (cmd_i.op == gxb_pkg::REQ_READ) && rd_hit;
      slot_value_q <= ((cmd_i.op == gxb_pkg::REQ_READ) && rd_hit) ? 32'(rd_word) : '0;
    end
  end

  assign added_o      = added_q;
  assign in_span_o    = in_span_q;
  assign rank_o       = rank_out_q;
  assign slot_valid_o = slot_valid_q;
  assign slot_value_o = slot_value_q;

  a_rank_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rank_q) == $countones(valid_q))
    else $error("rank out of step with slot valid bits");

  a_commit_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_en |-> !valid_q[pivot_i])
    else $error("insert commits onto an occupied slot");

  a_commit_pivot_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_en |-> ((acc_q >> pivot_i) == word_t'(1)))
    else $error("committed vector does not top out at its pivot");

endmodule

`default_nettype wire

@@ hdl/gf2_xor_basis_insert_query.sv @@
// GF(2) XOR basis in reduced echelon form with one slot per pivot bit. Pulse start while busy
// is low to issue a transaction: insert, span query, slot read or clear. Exactly one result
// per transaction appears for a single cycle with done_o high; the receiver cannot stall, so
// capture it then. A single read port walks the slot store one slot per cycle: a read or clear
// goes straight to the finish step, a query runs a reduce sweep, and an insert runs a reduce
// sweep and then, if it adds a vector, a downward pivot scan and an elimination sweep. busy
// stays high until the result cycle. Vector bits at or above WORD_BITS are ignored; rank is
// reported modulo 64.
`default_nettype none

module gf2_xor_basis_insert_query #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] vector_value_i,
  input  wire logic [4:0]  pivot_index_i,
  output logic             done_o,
  output logic             added_o,
  output logic             in_span_o,
  output logic [5:0]       rank_o,
  output logic             slot_valid_o,
  output logic [31:0]      slot_value_o
);

  localparam int unsigned IW = $clog2(WORD_BITS);

  gxb_pkg::gxb_cmd_t    cmd;
  gxb_pkg::gxb_status_t status;
  logic [IW-1:0]        slot_idx;
  logic [IW-1:0]        pivot;

  gxb_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .pivot_index_i(pivot_index_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .slot_idx_o   (slot_idx),
    .pivot_o      (pivot),
    .done_o       (done_o)
  );

  gxb_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .slot_idx_i    (slot_idx),
    .pivot_i       (pivot),
    .vector_value_i(vector_value_i),
    .pivot_index_i (pivot_index_i),
    .status_o      (status),
    .added_o       (added_o),
    .in_span_o     (in_span_o),
    .rank_o        (rank_o),
    .slot_valid_o  (slot_valid_o),
    .slot_value_o  (slot_value_o)
  );

endmodule

`default_nettype wire

@@ bench/gf2_xor_basis_insert_query_test.sv @@
module gf2_xor_basis_insert_query_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BITS = 32;
  localparam int unsigned SETTLE_CYCLES = 3 * BITS + 24;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 1080;

  typedef struct packed {
    gxb_pkg::gxb_req_e op;
    logic [31:0]       word;
    logic [4:0]        pivot;
    logic              hold;  // launch only once every earlier transaction has answered
  } basis_req_t;

  typedef struct packed {
    logic        added;
    logic        in_span;
    logic [5:0]  rank;
    logic        slot_valid;
    logic [31:0] slot_value;
  } basis_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  req_type_i = gxb_pkg::REQ_INSERT;
  logic [31:0] vector_value_i = '0;
  logic [4:0]  pivot_index_i = '0;
  logic        busy;
  logic        done_o;
  logic        added_o;
  logic        in_span_o;
  logic [5:0]  rank_o;
  logic        slot_valid_o;
  logic [31:0] slot_value_o;

  gf2_xor_basis_insert_query #(.WORD_BITS(BITS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .vector_value_i (vector_value_i),
    .pivot_index_i  (pivot_index_i),
    .done_o         (done_o),
    .added_o        (added_o),
    .in_span_o      (in_span_o),
    .rank_o         (rank_o),
    .slot_valid_o   (slot_valid_o),
    .slot_value_o   (slot_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the basis store
  logic [31:0] basis_vec [BITS];
  logic [31:0] basis_held = '0;

  basis_req_t  pending_q [$];
  basis_resp_t resp_due_q [$];
  basis_req_t  cur_req = '0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          quiet_cycles = 0;
  int          gen_count = 0;
  logic [31:0] gen_words [$];
  logic [31:0] round_gens [$];

  function automatic logic [31:0] span_reduce(logic [31:0] w);
    logic [31:0] r;
    r = w;
    for (int i = 0; i < BITS; i++) begin
      if (basis_held[i] && w[i]) r ^= basis_vec[i];
    end
    return r;
  endfunction

  function automatic basis_resp_t basis_update(basis_req_t r);
    basis_resp_t o;
    logic [31:0] red;
    int top;
    o = '0;
    case (r.op)
      gxb_pkg::REQ_INSERT: begin
        red = span_reduce(r.word);
        if (red != '0) begin
          top = 0;
          for (int i = 0; i < BITS; i++) begin
            if (red[i]) top = i;
          end
          // keep the form reduced: clear the new pivot out of every other slot
          for (int j = 0; j < BITS; j++) begin
            if (j != top && basis_held[j] && basis_vec[j][top]) basis_vec[j] ^= red;
          end
          basis_vec[top] = red;
          basis_held[top] = 1'b1;
          o.added = 1'b1;
        end
      end
      gxb_pkg::REQ_QUERY: o.in_span = (span_reduce(r.word) == '0);
      gxb_pkg::REQ_READ: begin
        if (basis_held[r.pivot]) begin
          o.slot_valid = 1'b1;
          o.slot_value = basis_vec[r.pivot];
        end
      end
      default: begin
        basis_held = '0;
        for (int i = 0; i < BITS; i++) basis_vec[i] = '0;
      end
    endcase
    o.rank = 6'($countones(basis_held));
    return o;
  endfunction

  task automatic push_item(gxb_pkg::gxb_req_e op, logic [31:0] word, logic [4:0] pivot,
                           logic hold);
    basis_req_t it;
    it.op = op;
    it.word = word;
    it.pivot = pivot;
    it.hold = hold;
    pending_q = {pending_q, it};
    gen_count++;
    if (op == gxb_pkg::REQ_INSERT) gen_words = {gen_words, word};
    if (op == gxb_pkg::REQ_CLEAR) gen_words.delete();
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return $urandom & $urandom & $urandom;
      4: return ~($urandom & $urandom & $urandom);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] xor_pick(logic [31:0] words [$]);
    logic [31:0] acc;
    acc = '0;
    foreach (words[i]) begin
      if ($urandom_range(0, 1)) acc ^= words[i];
    end
    return acc;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: hold start until the transaction is taken, then idle in bursts
  always @(posedge clk_i) begin
    logic took;
    logic go;
    basis_req_t nxt;
    took = rst_ni && start && !busy;
    go = start && !took;
    if (took) begin
      resp_due_q = {resp_due_q, basis_update(cur_req)};
      items_sent <= items_sent + 1;
    end
    if (!rst_ni) begin
      go = 1'b0;
    end else if (!go) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 &&
                   (!pending_q[0].hold ||
                    (!took && items_sent == results_seen + int'(done_o)))) begin
        nxt = pending_q.pop_front();
        cur_req <= nxt;
        req_type_i <= nxt.op;
        vector_value_i <= nxt.word;
        pivot_index_i <= nxt.pivot;
        go = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 110)
                                                  : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    start <= go;
  end

  // Monitor: every strobed result must match the oldest pending expectation
  always @(posedge clk_i) begin
    basis_resp_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen <= results_seen + 1;
      if (resp_due_q.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual rank %0d", $time, rank_o);
        fail_count++;
      end else begin
        want = resp_due_q.pop_front();
        check_field("added", want.added, added_o);
        check_field("in_span", want.in_span, in_span_o);
        check_field("rank", want.rank, rank_o);
        check_field("slot_valid", want.slot_valid, slot_valid_o);
        check_field("slot_value", want.slot_value, slot_value_o);
      end
    end
  end

  // Watchdog on cycles with no transaction and no result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int k;
    int n;
    gxb_pkg::gxb_req_e op;

    // Directed: empty store, extreme words, dependent insert, elimination, clear
    push_item(gxb_pkg::REQ_READ, 32'hFFFF_FFFF, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'h0, 5'd31, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'h0, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'h1, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'h1, 5'd31, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'h8000_0000, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'hFFFF_FFFF, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'h8000_0001, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'h8000_0001, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'hFFFF_FFFF, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'h0000_0002, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd31, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd30, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'h4000_0000, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd30, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd29, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd5, 1'b0);
    push_item(gxb_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 5'd31, 1'b0);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd31, 1'b0);
    push_item(gxb_pkg::REQ_QUERY, 32'hFFFF_FFFF, 5'd0, 1'b0);
    push_item(gxb_pkg::REQ_INSERT, 32'hFFFF_FFFF, 5'd0, 1'b1);
    push_item(gxb_pkg::REQ_READ, 32'h0, 5'd31, 1'b0);

    // Random: rounds of inserts with span queries and reads mixed in
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        push_item(gxb_pkg::REQ_CLEAR, $urandom, 5'($urandom), 1'b0);
      end
      round_gens.delete();
      if ($urandom_range(0, 3) == 0) begin
        // low-rank round: many inserts fall in the span
        repeat ($urandom_range(1, 8)) round_gens = {round_gens, rand_word()};
      end
      n = $urandom_range(4, 48);
      repeat (n) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          push_item(gxb_pkg::REQ_INSERT,
                    (round_gens.size() != 0) ? xor_pick(round_gens) : rand_word(),
                    5'($urandom), $urandom_range(0, 60) == 0);
        end else if (k < 70) begin
          push_item(gxb_pkg::REQ_QUERY, xor_pick(gen_words), 5'($urandom),
                    $urandom_range(0, 60) == 0);
        end else if (k < 78) begin
          push_item(gxb_pkg::REQ_QUERY, rand_word(), 5'($urandom), 1'b0);
        end else if (k < 94) begin
          push_item(gxb_pkg::REQ_READ, $urandom, 5'($urandom), $urandom_range(0, 60) == 0);
        end else begin
          op = gxb_pkg::gxb_req_e'($urandom_range(0, 3));
          push_item(op, $urandom, 5'($urandom), 1'b0);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || items_sent != results_seen) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (resp_due_q.size() != 0) begin
      $display("%0t ns: missing results: expected %0d more, actual 0", $time,
               resp_due_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
